>>> sv/fractional_polynomial_resampler_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef FRACTIONAL_POLYNOMIAL_RESAMPLER_ASSERT_SVH
`define FRACTIONAL_POLYNOMIAL_RESAMPLER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define FPR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fpr_pkg.sv
// Types, codes and coefficient constants of the polynomial resampler.
package fpr_pkg;

  localparam int RATE_W     = 20;
  localparam int ORDER_W    = 3;
  localparam int CFG_DATA_W = 20;
  localparam int HIST_DEPTH = 4;
  localparam int MUL_W      = 10;  // signed multiplier operand of the shared MAC
  localparam int K_W        = 8;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_RATE_STEP    = 1'b0;
  localparam cfg_idx_t REG_INTERP_ORDER = 1'b1;

  localparam logic [ORDER_W-1:0] ORD_QUAD  = 3'd3;
  localparam logic [ORDER_W-1:0] ORD_CUBIC = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Node window and polynomial: linear, quadratic on s0..s2, quadratic on s1..s3, cubic.
  typedef enum logic [1:0] {
    MODE_LIN,
    MODE_QLO,
    MODE_QHI,
    MODE_CUB
  } mode_e;

  typedef logic signed [K_W-1:0] kval_t;

  // Integer weights: coefficient c[i] = sum over history j of COEF_K[mode][i][j] * s[j].
  localparam kval_t COEF_K [4][4][4] = '{
    '{ '{ 8'sd0,  8'sd1,   8'sd0,  8'sd0 },
       '{ 8'sd0, -8'sd1,   8'sd1,  8'sd0 },
       '{ 8'sd0,  8'sd0,   8'sd0,  8'sd0 },
       '{ 8'sd0,  8'sd0,   8'sd0,  8'sd0 } },
    '{ '{ 8'sd2,  8'sd0,   8'sd0,  8'sd0 },
       '{-8'sd3,  8'sd4,  -8'sd1,  8'sd0 },
       '{ 8'sd1, -8'sd2,   8'sd1,  8'sd0 },
       '{ 8'sd0,  8'sd0,   8'sd0,  8'sd0 } },
    '{ '{ 8'sd0,  8'sd2,   8'sd0,  8'sd0 },
       '{ 8'sd0, -8'sd3,   8'sd4, -8'sd1 },
       '{ 8'sd0,  8'sd1,  -8'sd2,  8'sd1 },
       '{ 8'sd0,  8'sd0,   8'sd0,  8'sd0 } },
    '{ '{ 8'sd6,  8'sd0,   8'sd0,  8'sd0 },
       '{-8'sd11, 8'sd18, -8'sd9,  8'sd2 },
       '{ 8'sd6, -8'sd15,  8'sd12, -8'sd3 },
       '{-8'sd1,  8'sd3,  -8'sd3,  8'sd1 } }
  };

  function automatic logic [1:0] order_degree(input logic [ORDER_W-1:0] order);
    logic [1:0] deg;
    unique case (order)
      ORD_QUAD:  deg = 2'd2;
      ORD_CUBIC: deg = 2'd3;
      default:   deg = 2'd1;
    endcase
    return deg;
  endfunction

endpackage

>>> sv/fpr_mac.sv
// Shared multiply-add unit: x * m + a, optionally floored by 2^8.
module fpr_mac #(
  parameter int AW = 41,
  parameter int PW = 51
) (
  input  logic signed [AW-1:0]              x_i,
  input  logic signed [fpr_pkg::MUL_W-1:0]  m_i,
  input  logic signed [PW-1:0]              a_i,
  input  logic                              shift8_i,
  output logic signed [AW-1:0]              r_o
);
  import fpr_pkg::*;

  logic signed [PW-1:0] x_ext;
  logic signed [PW-1:0] m_ext;
  logic signed [PW-1:0] sum;

  assign x_ext = PW'(x_i);
  assign m_ext = PW'(m_i);
  assign sum   = x_ext * m_ext + a_i;
  assign r_o   = shift8_i ? AW'(sum >>> 8) : AW'(sum);

endmodule

>>> sv/fpr_div3.sv
// Divide-by-three of an unsigned value by reciprocal multiplication, result registered.
`include "fractional_polynomial_resampler_assert.svh"

module fpr_div3 #(
  parameter int DW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);
  import fpr_pkg::*;

  // 2^RS / 3 rounded up gives the exact floor for every dividend below 2^DW
  localparam int RS = DW + 1;
  localparam int PW = DW + RS;
  localparam logic [RS-1:0] RECIP = RS'(((64'd1 << RS) + 64'd2) / 64'd3);

  logic          busy_q, busy_d;
  logic [DW-1:0] dv_q, dv_d;
  logic [DW-1:0] quot_q, quot_d;
  logic [PW-1:0] prod;

  assign prod   = PW'(dv_q) * PW'(RECIP);
  assign busy_o = busy_q;
  assign quot_o = quot_q;

  always_comb begin
    busy_d = 1'b0;
    dv_d   = dv_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      dv_d   = dividend_i;
    end else if (busy_q) begin
      // keep the integer part of dividend times reciprocal
      quot_d = prod[PW-1:RS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q   <= dv_d;
    quot_q <= quot_d;
  end

  `FPR_ASSERT_IMP(a_div3_no_restart, start_i, !busy_o, "divider restarted while busy")
  `FPR_ASSERT_NEXT(a_div3_load, start_i, busy_o, "divider did not start")
  `FPR_ASSERT_NEXT(a_div3_single, busy_o && !start_i, !busy_o, "divider busy too long")

endmodule

>>> sv/fractional_polynomial_resampler.sv
// Top level of the fractional polynomial resampler: sequencer, state and output stage.
//
//  channel | direction | handshake                | beat payload
//  --------+-----------+--------------------------+-------------------------------
//  cfg     | in        | cfg_we_i                 | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o  | in_sample_i
//  out     | out       | out_valid_o / out_stall_i| out_sample_o, last_of_run_o
//
// After an input beat is taken, each result runs through the coefficient, load, multiply,
// round and emit steps of the sequencer on the shared MAC; for cubic order the divide-by-three
// by reciprocal multiplication adds a divider step before emit.
// in_stall_o is high from the accepted beat until its last result sits in the output register.
// A stalled output register holds the sequencer in its emit step.
// Reset clears history, phase, and sets rate 1.0 and linear order; no clearing pass.
`include "fractional_polynomial_resampler_assert.svh"

module fractional_polynomial_resampler #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  fpr_pkg::cfg_idx_t                   cfg_index_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_o,
  output logic                                last_of_run_o
);
  import fpr_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PF     = PHASE_FRAC_BITS;
  localparam int PH_W   = PF + 5;
  localparam int ST_W   = PF + 4;
  localparam int COEF_W = SW + 6;
  localparam int ACC_W  = SW + 25;
  localparam int PROD_W = ACC_W + MUL_W;
  localparam int DW     = SW + 2;
  localparam int SH_L   = (PF >= 16) ? PF - 16 : 0;
  localparam int SH_R   = (PF < 16) ? 16 - PF : 0;

  localparam logic [PH_W-1:0] PH_ONE   = PH_W'(1) << PF;
  localparam logic [ST_W-1:0] STEP_MIN = ST_W'(1) << (PF - 6);
  localparam logic [PF-1:0]   MU_HALF  = PF'(1) << (PF - 1);

  localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W + 2 - SW){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W:0] M_HI   = SAT_HI * 3 + 2;
  localparam logic signed [ACC_W:0] M_LO   = SAT_LO * 3;
  localparam logic signed [ACC_W:0] BIAS_1 = (ACC_W + 1)'(1) <<< 15;
  localparam logic signed [ACC_W:0] BIAS_2 = (ACC_W + 1)'(1) <<< 16;
  localparam logic signed [ACC_W:0] BIAS_6 = (ACC_W + 1)'(3) <<< 16;

  state_e state_q, state_d;

  logic [RATE_W-1:0]  rate_q, rate_d;
  logic [ORDER_W-1:0] order_q, order_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic signed [SW-1:0] hist_q [HIST_DEPTH];
  logic signed [SW-1:0] hist_d [HIST_DEPTH];

  logic [1:0] node_q, node_d;
  logic [1:0] cidx_q, cidx_d;
  logic [1:0] dig_q, dig_d;

  logic signed [COEF_W-1:0] cf_q, cf_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  pp_q, pp_d;
  logic signed [SW-1:0]     res_q, res_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_sample_q, out_sample_d;
  logic                 out_last_q, out_last_d;

  logic [PF+19:0] step_raw;
  logic [ST_W-1:0] step_conv;
  logic [ST_W-1:0] step;
  logic [PH_W-1:0] ph_dec;
  logic [PH_W-1:0] phase_sum;
  logic [PF-1:0]   mu;
  logic [PF+15:0]  mu_w;
  logic [15:0]     mu16;
  logic [16:0]     t_val;
  logic [7:0]      digit;
  mode_e           mode;
  logic [1:0]      deg;
  logic            accept;
  logic            out_free;

  logic signed [ACC_W-1:0]  mac_x;
  logic signed [MUL_W-1:0]  mac_m;
  logic signed [PROD_W-1:0] mac_a;
  logic                     mac_sh;
  logic signed [ACC_W-1:0]  mac_r;

  logic signed [ACC_W:0] acc_x;
  logic signed [ACC_W:0] y_round;
  logic signed [ACC_W:0] y_sat;
  logic signed [ACC_W:0] m_div;
  logic signed [ACC_W:0] m_cl;
  logic [DW-1:0]         div_dividend;
  logic                  div_start;
  logic                  div_busy;
  logic [DW-1:0]         div_quot;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // step from Q4.16 into phase units, floored at 1/64
  assign step_raw  = ((PF + 20)'(rate_q) << SH_L) >> SH_R;
  assign step_conv = ST_W'(step_raw);
  assign step      = (step_conv < STEP_MIN) ? STEP_MIN : step_conv;

  assign ph_dec    = (phase_q >= PH_ONE) ? phase_q - PH_ONE : phase_q;
  assign phase_sum = phase_q + PH_W'(step);

  assign mu    = phase_q[PF-1:0];
  assign mu_w  = ((PF + 16)'(mu) << SH_R) >> SH_L;
  assign mu16  = mu_w[15:0];
  assign deg   = order_degree(order_q);

  always_comb begin
    unique case (order_q)
      ORD_QUAD:  mode = (mu <= MU_HALF) ? MODE_QLO : MODE_QHI;
      ORD_CUBIC: mode = MODE_CUB;
      default:   mode = MODE_LIN;
    endcase
  end

  assign t_val = (mode == MODE_LIN || mode == MODE_QHI) ? {1'b0, mu16} : {1'b1, mu16};

  always_comb begin
    case (dig_q)
      2'd0:    digit = t_val[7:0];
      2'd1:    digit = t_val[15:8];
      default: digit = {7'd0, t_val[16]};
    endcase
  end

  // MAC operand selection
  always_comb begin
    mac_x  = acc_q;
    mac_m  = MUL_W'(signed'({1'b0, digit}));
    mac_a  = '0;
    mac_sh = 1'b0;
    if (state_q == ST_COEF) begin
      mac_x = ACC_W'(hist_q[node_q]);
      mac_m = MUL_W'(COEF_K[mode][cidx_q][node_q]);
      mac_a = (node_q == 2'd0) ? '0 : PROD_W'(cf_q);
    end else begin
      case (dig_q)
        2'd0: begin
          mac_sh = 1'b1;
        end
        2'd1: begin
          mac_a  = PROD_W'(pp_q);
          mac_sh = 1'b1;
        end
        default: begin
          mac_a = PROD_W'(pp_q) + (PROD_W'(cf_q) <<< 16);
        end
      endcase
    end
  end

  fpr_mac #(
    .AW (ACC_W),
    .PW (PROD_W)
  ) u_mac (
    .x_i      (mac_x),
    .m_i      (mac_m),
    .a_i      (mac_a),
    .shift8_i (mac_sh),
    .r_o      (mac_r)
  );

  // rounding and saturation
  assign acc_x = (ACC_W + 1)'(acc_q);

  always_comb begin
    if (mode == MODE_LIN) begin
      y_round = (acc_x + BIAS_1) >>> 16;
    end else begin
      y_round = (acc_x + BIAS_2) >>> 17;
    end
    if (y_round > SAT_HI) begin
      y_sat = SAT_HI;
    end else if (y_round < SAT_LO) begin
      y_sat = SAT_LO;
    end else begin
      y_sat = y_round;
    end
  end

  // cubic: floor(m / 3) with m clamped to the range that maps into the sample width
  always_comb begin
    m_div = (acc_x + BIAS_6) >>> 17;
    if (m_div > M_HI) begin
      m_cl = M_HI;
    end else if (m_div < M_LO) begin
      m_cl = M_LO;
    end else begin
      m_cl = m_div;
    end
  end

  assign div_dividend = DW'(m_cl - M_LO);

  fpr_div3 #(
    .DW (DW)
  ) u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (ph_dec < PH_ONE) ? ST_COEF : ST_IDLE;
        end
      end
      ST_COEF: begin
        if (node_q == 2'd3) begin
          state_d = (cidx_q == deg) ? ST_LOAD : ST_MUL;
        end
      end
      ST_LOAD: state_d = ST_COEF;
      ST_MUL: begin
        if (dig_q == 2'd2) begin
          state_d = (cidx_q == 2'd0) ? ST_ROUND : ST_COEF;
        end
      end
      ST_ROUND: state_d = (mode == MODE_CUB) ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = (phase_sum < PH_ONE) ? ST_COEF : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    hist_d       = hist_q;
    phase_d      = phase_q;
    node_d       = node_q;
    cidx_d       = cidx_q;
    dig_d        = dig_q;
    cf_d         = cf_q;
    acc_d        = acc_q;
    pp_d         = pp_q;
    res_d        = res_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_d[i] = hist_q[i + 1];
          end
          hist_d[HIST_DEPTH-1] = in_sample_i;
          phase_d = ph_dec;
          node_d  = 2'd0;
          cidx_d  = deg;
        end
      end
      ST_COEF: begin
        cf_d   = COEF_W'(mac_r);
        node_d = node_q + 2'd1;
        dig_d  = 2'd0;
      end
      ST_LOAD: begin
        acc_d  = ACC_W'(cf_q) <<< 16;
        cidx_d = cidx_q - 2'd1;
      end
      ST_MUL: begin
        dig_d = dig_q + 2'd1;
        if (dig_q == 2'd2) begin
          acc_d  = mac_r;
          cidx_d = cidx_q - 2'd1;
        end else begin
          pp_d = mac_r;
        end
      end
      ST_ROUND: begin
        if (mode == MODE_CUB) begin
          div_start = 1'b1;
        end else begin
          res_d = SW'(y_sat);
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          // quotient is offset by the most negative sample: flip the sign bit
          res_d = {~div_quot[SW-1], div_quot[SW-2:0]};
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = res_q;
          out_last_d   = (phase_sum >= PH_ONE);
          phase_d      = phase_sum;
          node_d       = 2'd0;
          cidx_d       = deg;
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_comb begin
    rate_d  = rate_q;
    order_d = order_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RATE_STEP:    rate_d  = cfg_data_i[RATE_W-1:0];
        REG_INTERP_ORDER: order_d = cfg_data_i[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_W'(65536);
      order_q     <= ORDER_W'(2);
      phase_q     <= '0;
      node_q      <= '0;
      cidx_q      <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      order_q     <= order_d;
      phase_q     <= phase_d;
      node_q      <= node_d;
      cidx_q      <= cidx_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      hist_q      <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cf_q         <= cf_d;
    acc_q        <= acc_d;
    pp_q         <= pp_d;
    res_q        <= res_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign last_of_run_o = out_last_q;

  `FPR_ASSERT_IMP(a_phase_in_window, state_q == ST_COEF, phase_q < PH_ONE, "evaluating outside the unit interval")
  `FPR_ASSERT_NEXT(a_emit_beat, state_q == ST_EMIT && out_free, out_valid_o && out_sample_o == $past(res_q), "result not moved to output register")
  `FPR_ASSERT_IMP(a_div_cubic_only, state_q == ST_DIV, order_q == ORD_CUBIC, "divider used outside cubic order")

endmodule
